FILE: sv/bsd_pkg.sv
// bsd_pkg: shared types, constants and the sextet lookup for the base64 stream decoder
// used by bsd_front, bsd_fifo, bsd_back and base64_stream_decoder; no dependencies
`default_nettype none

package bsd_pkg;

    // default depth of the command queue between front and back
    localparam int unsigned BSD_FIFO_DEPTH = 4;

    // padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // alphabet offsets
    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;
    localparam logic [5:0] PLUS_VALUE   = 6'd62;
    localparam logic [5:0] SLASH_VALUE  = 6'd63;

    // m_tuser bit positions
    localparam int unsigned USER_IS_STATUS = 0;
    localparam int unsigned USER_OK        = 1;

    // decoded character: value plus a flag for characters outside the alphabet
    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    // one command from front to back: up to three bytes, then an optional status
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        status;
        logic        ok;
    } bsd_cmd_t;

    // map one character to its sextet
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] d;
        s.bad   = 1'b0;
        s.value = '0;
        d       = '0;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            d       = c - 8'h41;
            s.value = d[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d       = c - 8'h61 + LOWER_OFFSET;
            s.value = d[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d       = c - 8'h30 + DIGIT_OFFSET;
            s.value = d[5:0];
        end else if (c == 8'h2B) begin
            s.value = PLUS_VALUE;
        end else if (c == 8'h2F) begin
            s.value = SLASH_VALUE;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bsd_front.sv
// bsd_front: accepts characters, tracks quad position and padding, builds byte/status commands
// depends on bsd_pkg
`default_nettype none

module bsd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] ch
    input  wire logic [0:0]       s_tuser,   // [0] has_char
    input  wire logic             s_tlast,
    input  wire logic             fifo_full,
    output logic                  push,
    output bsd_pkg::bsd_cmd_t     cmd
);
    import bsd_pkg::*;

    logic [1:0]  qpos_reg, qpos_next;
    logic [17:0] held_reg, held_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        accept;
    sextet_t     sx;
    logic        is_pad;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign sx       = sextet_of(s_tdata);
    assign is_pad   = (s_tdata == PAD_CHAR);

    // state step for the offered item
    always_comb begin
        qpos_next  = qpos_reg;
        held_next  = held_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        cmd        = '0;

        if (s_tuser[0] && !err_reg) begin
            unique case (qpos_reg)
                2'd0, 2'd1: begin
                    if (sx.bad || (qpos_reg == 2'd0 && pad_reg)) begin
                        err_next = 1'b1;
                    end else begin
                        held_next = {held_reg[11:0], sx.value};
                        qpos_next = qpos_reg + 2'd1;
                    end
                end
                2'd2: begin
                    if (is_pad) begin
                        pad_next  = 1'b1;
                        qpos_next = 2'd3;
                    end else if (sx.bad) begin
                        err_next = 1'b1;
                    end else begin
                        held_next = {held_reg[11:0], sx.value};
                        qpos_next = 2'd3;
                    end
                end
                default: begin
                    // fourth character closes the quad
                    if (pad_reg) begin
                        if (!is_pad) begin
                            err_next = 1'b1;
                        end else begin
                            cmd.nbytes = 2'd1;
                            cmd.word   = {held_reg[11:4], 16'h0000};
                            qpos_next  = 2'd0;
                            held_next  = '0;
                        end
                    end else if (is_pad) begin
                        cmd.nbytes = 2'd2;
                        cmd.word   = {held_reg[17:2], 8'h00};
                        pad_next   = 1'b1;
                        qpos_next  = 2'd0;
                        held_next  = '0;
                    end else if (sx.bad) begin
                        err_next = 1'b1;
                    end else begin
                        cmd.nbytes = 2'd3;
                        cmd.word   = {held_reg, sx.value};
                        qpos_next  = 2'd0;
                        held_next  = '0;
                    end
                end
            endcase
        end

        // end of string: status result, then back to reset state
        if (s_tlast) begin
            cmd.status = 1'b1;
            cmd.ok     = !err_next && (qpos_next == 2'd0);
            qpos_next  = '0;
            held_next  = '0;
            pad_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    assign push = accept && (cmd.nbytes != 2'd0 || cmd.status);

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qpos_reg <= '0;
            held_reg <= '0;
            pad_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end else if (accept) begin
            qpos_reg <= qpos_next;
            held_reg <= held_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bsd_fifo.sv
// bsd_fifo: short command queue between front and back
// depends on bsd_pkg
`default_nettype none

module bsd_fifo #(
    parameter int unsigned DEPTH = bsd_pkg::BSD_FIFO_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire bsd_pkg::bsd_cmd_t wr_cmd,
    output logic                   full,
    input  wire logic              pop,
    output bsd_pkg::bsd_cmd_t      head,
    output logic                   empty
);
    import bsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bsd_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bsd_back.sv
// bsd_back: expands queued commands into result items through an output register
// depends on bsd_pkg
`default_nettype none

module bsd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bsd_pkg::bsd_cmd_t head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [7:0] data_byte
    output logic [1:0]             m_tuser,   // [0] is_status, [1] ok
    output logic                   m_tlast    // last_result
);
    import bsd_pkg::*;

    bsd_cmd_t   cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic       m_tlast_reg;

    logic [2:0] total;
    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       finishing;
    logic       is_stat;
    logic [7:0] sel_byte;
    logic [7:0] data_next;
    logic [1:0] user_next;

    // result selection for the current command
    always_comb begin
        total     = {1'b0, cur_reg.nbytes} + {2'b00, cur_reg.status};
        out_free  = !m_tvalid_reg || m_tready;
        emit      = cur_valid_reg && out_free;
        is_last   = ({1'b0, idx_reg} + 3'd1) == total;
        finishing = emit && is_last;
        pop       = !empty && (!cur_valid_reg || finishing);
        is_stat   = (idx_reg == cur_reg.nbytes);
        unique case (idx_reg)
            2'd0:    sel_byte = cur_reg.word[23:16];
            2'd1:    sel_byte = cur_reg.word[15:8];
            default: sel_byte = cur_reg.word[7:0];
        endcase
        data_next                 = is_stat ? 8'h00 : sel_byte;
        user_next                 = '0;
        user_next[USER_IS_STATUS] = is_stat;
        user_next[USER_OK]        = is_stat && cur_reg.ok;
    end

    // current command and result index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (finishing) begin
            cur_valid_reg <= 1'b0;
        end else if (emit) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= user_next;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: sv/base64_stream_decoder.sv
// base64_stream_decoder: commands pass the queue, current-command register and output register
// throughput one character per cycle while the queue is not full; results leave the back end
// at one item per cycle while m_tready holds; a full quad gives three bytes, so the command
// queue absorbs bursts of results; s_tready drops only when the command queue is full
// aresetn (synchronous, active low) clears decode state, queue and output valid
// depends on bsd_pkg, bsd_front, bsd_fifo, bsd_back
`default_nettype none

module base64_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = bsd_pkg::BSD_FIFO_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic [0:0] s_tuser,   // [0] has_char
    input  wire logic       s_tlast,   // last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] data_byte
    output logic [1:0]      m_tuser,   // [0] is_status, [1] ok
    output logic            m_tlast    // last_result
);
    import bsd_pkg::*;

    bsd_cmd_t front_cmd;
    bsd_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    // character intake and classification
    bsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .fifo_full (full),
        .push      (push),
        .cmd       (front_cmd)
    );

    // command queue
    bsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (front_cmd),
        .full    (full),
        .pop     (pop),
        .head    (head_cmd),
        .empty   (empty)
    );

    // result serialization
    bsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_cmd),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
